### rtl/core/csg_pkg.sv
// Shared types and constants for the composition sequence generator.
package csg_pkg;

	localparam int TOTAL_W       = 8;
	localparam int PARTS_USED_W  = 5;
	localparam int CFG_DATA_W    = 8;
	localparam int CFG_INDEX_W   = 1;
	localparam int PART_INDEX_W  = 4;
	localparam int PART_AMOUNT_W = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_TOTAL      = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PARTS_USED = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_PICK,
		S_RD_T,
		S_RD_U,
		S_WR_H,
		S_WR_0,
		S_WR_H1,
		S_RD_K,
		S_CHK,
		S_PRE,
		S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		RD_H,
		RD_H1,
		RD_K1,
		RD_EMIT_CUR,
		RD_EMIT_NXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_FIRST,
		WR_H_ZERO,
		WR_ZERO_DEC,
		WR_H1_INC
	} wr_sel_t;

	typedef struct packed {
		logic    init;
		logic    pick_h;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_sel_t wr_sel;
		logic    latch_t;
		logic    latch_u;
		logic    commit;
		logic    set_more;
		logic    emit_clear;
		logic    emit_load;
	} cmd_t;

	typedef struct packed {
		logic wrap;
		logic rd_zero;
		logic emit_last;
		logic out_free;
		logic more;
	} status_t;

endpackage

### rtl/core/csg_ctrl.sv
// Sequencing state machine for the composition sequence generator.
module csg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             restart,
	input  csg_pkg::status_t status,
	output csg_pkg::cmd_t    cmd
);
	import csg_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.rd_sel = RD_H;
		cmd.wr_sel = WR_FIRST;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.emit_clear = 1'b1;
					if (restart || !status.more) begin
						state_d = S_INIT;
					end else begin
						state_d = S_PICK;
					end
				end
			end
			S_INIT: begin
				cmd.init   = 1'b1;
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_FIRST;
				state_d    = S_PRE;
			end
			S_PICK: begin
				cmd.pick_h = 1'b1;
				state_d    = S_RD_T;
			end
			S_RD_T: begin
				if (status.wrap) begin
					state_d = S_INIT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_H;
					state_d    = S_RD_U;
				end
			end
			S_RD_U: begin
				if (status.rd_zero) begin
					state_d = S_INIT;
				end else begin
					cmd.latch_t = 1'b1;
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_H1;
					state_d     = S_WR_H;
				end
			end
			S_WR_H: begin
				cmd.latch_u = 1'b1;
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_H_ZERO;
				state_d     = S_WR_0;
			end
			S_WR_0: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_ZERO_DEC;
				state_d    = S_WR_H1;
			end
			S_WR_H1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_H1_INC;
				cmd.commit = 1'b1;
				state_d    = S_RD_K;
			end
			S_RD_K: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_K1;
				state_d    = S_CHK;
			end
			S_CHK: begin
				cmd.set_more = 1'b1;
				state_d      = S_PRE;
			end
			S_PRE: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_EMIT_CUR;
				state_d    = S_EMIT;
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit_load = 1'b1;
					if (status.emit_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_EMIT_NXT;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/csg_dp.sv
// Datapath of the composition sequence generator: config, part memory, output register.
module csg_dp #(
	parameter int MAX_PARTS   = 16,
	parameter int AMOUNT_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [csg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [csg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  csg_pkg::cmd_t                        cmd,
	output csg_pkg::status_t                     status,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [csg_pkg::PART_INDEX_W-1:0]     part_index,
	output logic [csg_pkg::PART_AMOUNT_W-1:0]    part_amount,
	output logic                                 last_part,
	output logic                                 more_left
);
	import csg_pkg::*;

	localparam int IW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
	localparam int KW = $clog2(MAX_PARTS + 1);

	logic [TOTAL_W-1:0]      total_q;
	logic [PARTS_USED_W-1:0] parts_used_q;

	logic [AMOUNT_BITS-1:0]  mem [MAX_PARTS];
	logic [MAX_PARTS-1:0]    valid_q;
	logic [AMOUNT_BITS-1:0]  rd_q;
	logic                    rd_vld_q;

	logic [AMOUNT_BITS-1:0]  carry_q;
	logic [IW-1:0]           pos_q;
	logic                    more_q;
	logic [IW-1:0]           h_q;
	logic [AMOUNT_BITS-1:0]  t_q;
	logic [AMOUNT_BITS-1:0]  u_q;
	logic [IW-1:0]           emit_q;

	logic                    out_valid_q;
	logic [PART_INDEX_W-1:0] part_index_q;
	logic [PART_AMOUNT_W-1:0] part_amount_q;
	logic                    last_part_q;
	logic                    more_left_q;

	logic [KW-1:0]           k;
	logic [KW-1:0]           k_m1;
	logic [KW-1:0]           hp1;
	logic [31:0]             total_ext;
	logic [AMOUNT_BITS-1:0]  total_m;
	logic [AMOUNT_BITS-1:0]  rd_data;
	logic [31:0]             rd_ext;
	logic [31:0]             emit_ext;
	logic [IW-1:0]           rd_addr;
	logic [IW-1:0]           wr_addr;
	logic [AMOUNT_BITS-1:0]  wr_data;
	logic                    emit_last;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= TOTAL_W'(1);
			parts_used_q <= PARTS_USED_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TOTAL:      total_q      <= cfg_data[TOTAL_W-1:0];
				CFG_PARTS_USED: parts_used_q <= cfg_data[PARTS_USED_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the part count to 1..MAX_PARTS
	always_comb begin
		if (parts_used_q == '0) begin
			k = KW'(1);
		end else if (32'(parts_used_q) > MAX_PARTS) begin
			k = KW'(MAX_PARTS);
		end else begin
			k = KW'(parts_used_q);
		end
	end

	assign k_m1      = k - KW'(1);
	assign hp1       = KW'(h_q) + KW'(1);
	assign total_ext = 32'(total_q);
	assign total_m   = total_ext[AMOUNT_BITS-1:0];
	assign rd_data   = rd_vld_q ? rd_q : '0;
	assign rd_ext    = 32'(rd_data);
	assign emit_ext  = 32'(emit_q);
	assign emit_last = (KW'(emit_q) == k_m1);

	always_comb begin
		rd_addr = h_q;
		unique case (cmd.rd_sel)
			RD_H:        rd_addr = h_q;
			RD_H1:       rd_addr = hp1[IW-1:0];
			RD_K1:       rd_addr = k_m1[IW-1:0];
			RD_EMIT_CUR: rd_addr = emit_q;
			RD_EMIT_NXT: rd_addr = emit_q + IW'(1);
			default:     rd_addr = h_q;
		endcase
	end

	always_comb begin
		wr_addr = '0;
		wr_data = total_m;
		unique case (cmd.wr_sel)
			WR_FIRST: begin
				wr_addr = '0;
				wr_data = total_m;
			end
			WR_H_ZERO: begin
				wr_addr = h_q;
				wr_data = '0;
			end
			WR_ZERO_DEC: begin
				wr_addr = '0;
				wr_data = t_q - AMOUNT_BITS'(1);
			end
			WR_H1_INC: begin
				wr_addr = hp1[IW-1:0];
				wr_data = u_q + AMOUNT_BITS'(1);
			end
			default: ;
		endcase
	end

	// Part memory
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Entry valid bits: an entry not written since the last restart reads as zero.
	// A restart writes entry zero, so only its bit survives the clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				valid_q <= MAX_PARTS'(1);
			end else if (cmd.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
			pos_q   <= '0;
			more_q  <= 1'b0;
		end else begin
			if (cmd.init) begin
				carry_q <= total_m;
				pos_q   <= '0;
				more_q  <= (k != KW'(1)) && (total_m != '0);
			end else begin
				if (cmd.pick_h && (carry_q > AMOUNT_BITS'(1))) begin
					pos_q <= '0;
				end
				if (cmd.commit) begin
					pos_q   <= hp1[IW-1:0];
					carry_q <= t_q;
				end
				if (cmd.set_more) begin
					more_q <= (rd_data != total_m);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pick_h) begin
			h_q <= (carry_q > AMOUNT_BITS'(1)) ? '0 : pos_q;
		end
		if (cmd.latch_t) begin
			t_q <= rd_data;
		end
		if (cmd.latch_u) begin
			u_q <= rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= '0;
		end else if (cmd.emit_clear) begin
			emit_q <= '0;
		end else if (cmd.emit_load) begin
			emit_q <= emit_q + IW'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			part_index_q  <= emit_ext[PART_INDEX_W-1:0];
			part_amount_q <= rd_ext[PART_AMOUNT_W-1:0];
			last_part_q   <= emit_last;
			more_left_q   <= more_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign part_index  = part_index_q;
	assign part_amount = part_amount_q;
	assign last_part   = last_part_q;
	assign more_left   = more_left_q;

	assign status.wrap      = (hp1 >= k);
	assign status.rd_zero   = (rd_data == '0);
	assign status.emit_last = emit_last;
	assign status.out_free  = !out_valid_q || out_ready;
	assign status.more      = more_q;

endmodule

### rtl/core/composition_sequence_generator.sv
// Top level of the composition sequence generator: controller, datapath and checks.
// A restart begins at the first composition; an advance moves on from the current one, or falls
// back to the first composition. Each request streams k beats, k the clamped part count, and a new
// request is taken only after its last beat is loaded; out_ready low stalls the stream.
// Reset: asynchronous, active low; clears config to total 1 and one part, and forces the
// first request to start at the first composition. The part memory needs no sweep.
module composition_sequence_generator #(
	parameter int MAX_PARTS   = 16,
	parameter int AMOUNT_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [csg_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [csg_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [csg_pkg::PART_INDEX_W-1:0]     part_index,
	output logic [csg_pkg::PART_AMOUNT_W-1:0]    part_amount,
	output logic                                 last_part,
	output logic                                 more_left
);
	import csg_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Config writes land at once; user must send them while the block is idle; unchecked.
	assign cfg_ready = 1'b1;

	// The controller takes one request beat, walks the advance or restart steps,
	// then streams one beat per part through the output register.
	csg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the part amounts, the carry and position of the
	// last advance, the continuation flag and the output register.
	csg_dp #(
		.MAX_PARTS   (MAX_PARTS),
		.AMOUNT_BITS (AMOUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.part_index  (part_index),
		.part_amount (part_amount),
		.last_part   (last_part),
		.more_left   (more_left)
	);

`ifndef NO_ASSERTIONS
	// A result beat is loaded only into a free output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> status.out_free)
		else $error("result loaded over a pending beat");

	// An accepted request takes the controller out of idle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while a request is in progress");

	// The part memory is never read and written in the same cycle.
	a_mem_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.rd_en && cmd.wr_en))
		else $error("part memory read and written together");

	// No result beat leaves while the block is waiting for a request.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.emit_load)
		else $error("result emitted while idle");
`endif

endmodule
